@@ rtl/core/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg
// Types, event codes and the keypad letter table for the multi-tap entry block
// ----------------------------------------------------------------------------
`default_nettype none

package mte_pkg;

    localparam logic [2:0] FN_BEGIN  = 3'd0;
    localparam logic [2:0] FN_KEY    = 3'd1;
    localparam logic [2:0] FN_COMMIT = 3'd2;
    localparam logic [2:0] FN_LEFT   = 3'd3;
    localparam logic [2:0] FN_RIGHT  = 3'd4;
    localparam logic [2:0] FN_DELETE = 3'd5;
    localparam logic [2:0] FN_LOAD   = 3'd6;

    localparam logic [3:0] KEY_MAX   = 4'd9;
    localparam logic [4:0] TAP_LAST  = 5'd19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RGT_CHK0,
        ST_RGT_CHK1,
        ST_DONE
    } state_t;

    // tap count modulo five, tap count stays below twenty
    function automatic logic [2:0] tap_mod5(input logic [4:0] tap);
        logic [2:0] r;
        begin
            case (tap)
                5'd1, 5'd6, 5'd11, 5'd16: r = 3'd1;
                5'd2, 5'd7, 5'd12, 5'd17: r = 3'd2;
                5'd3, 5'd8, 5'd13, 5'd18: r = 3'd3;
                5'd4, 5'd9, 5'd14, 5'd19: r = 3'd4;
                default:                  r = 3'd0;
            endcase
            return r;
        end
    endfunction

    // letter list of a key, first letter in the top byte, short lists padded
    function automatic logic [39:0] key_row(input logic [3:0] key);
        logic [39:0] row;
        begin
            case (key)
                4'd0:    row = " -&!0";
                4'd1:    row = "/@.,1";
                4'd2:    row = "ABC2 ";
                4'd3:    row = "DEF3 ";
                4'd4:    row = "GHI4 ";
                4'd5:    row = "JKL5 ";
                4'd6:    row = "MNO6 ";
                4'd7:    row = "PQRS7";
                4'd8:    row = "TUV8 ";
                4'd9:    row = "WXYZ9";
                default: row = "     ";
            endcase
            return row;
        end
    endfunction

    function automatic logic [6:0] key_char(input logic [3:0] key, input logic [4:0] tap,
                                            input logic shift);
        logic        long_list;
        logic [2:0]  sel;
        logic [39:0] row;
        logic [7:0]  ch;
        begin
            long_list = (key == 4'd0) || (key == 4'd1) || (key == 4'd7) || (key == 4'd9);
            sel = long_list ? tap_mod5(tap) : {1'b0, tap[1:0]};
            row = key_row(key);
            ch  = row[8 * (3'd4 - sel) +: 8];
            if (!shift && ch >= "A" && ch <= "Z") begin
                ch = ch + 8'd32;
            end
            return ch[6:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/multitap_text_entry.sv @@
// ----------------------------------------------------------------------------
// multitap_text_entry
// Phone keypad multi-tap editor of a short zero terminated name
// ----------------------------------------------------------------------------
// sequencing: key, commit, left, delete, load and unused codes pass from the execute
// state to the done state, right reads one buffer entry per entry looked at, and
// begin scans the name (the name scan reads one buffer entry a cycle)
// throughput: one transaction in flight; s_ready rises with m_valid when the
// result register is free
// reset: synchronous active low; cursor before first entry, no previous key,
// tap count zero, buffer reads as zero through per-entry valid bits cleared at once
`default_nettype none

module multitap_text_entry
    import mte_pkg::*;
#(
    parameter int NAME_CHARS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_func,
    input  wire logic [3:0] s_key_digit,
    input  wire logic       s_shift_on,
    input  wire logic [3:0] s_load_index,
    input  wire logic [7:0] s_load_char,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [4:0]      m_cursor_report,
    output logic            m_char_written,
    output logic [3:0]      m_written_index,
    output logic [6:0]      m_written_char
);

    localparam int AW = $clog2(NAME_CHARS);
    localparam int PW = $clog2(NAME_CHARS + 1);
    localparam logic [PW-1:0] POS_MAX  = PW'(NAME_CHARS);
    localparam logic [PW-1:0] POS_ONE  = PW'(1);
    localparam logic [4:0]    RPT_LAST = 5'(NAME_CHARS - 1);

    // position is cursor plus one, so zero means before the first entry
    state_t         state_reg, state_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           prev_vld_reg, prev_vld_next;
    logic [3:0]     prev_key_reg, prev_key_next;
    logic [4:0]     tap_reg, tap_next;

    logic [2:0]     func_reg;
    logic [3:0]     key_reg;
    logic           shift_reg;
    logic [3:0]     lidx_reg;
    logic [7:0]     lchr_reg;

    logic [4:0]     res_rpt_reg, res_rpt_next;
    logic           res_wr_reg, res_wr_next;
    logic [3:0]     res_widx_reg, res_widx_next;
    logic [6:0]     res_wchr_reg, res_wchr_next;

    logic           m_valid_reg;
    logic [4:0]     m_rpt_reg;
    logic           m_wr_reg;
    logic [3:0]     m_widx_reg;
    logic [6:0]     m_wchr_reg;

    logic [NAME_CHARS-1:0] valid_reg;
    logic           vld_rd_reg;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     ram_rdata;
    logic           rd_nz;

    logic           out_free;
    logic           s_fire;
    logic           key_hit;
    logic [4:0]     tap_inc;
    logic [PW-1:0]  pos_adv;
    logic [PW-1:0]  pos_key;
    logic [4:0]     tap_key;
    logic [6:0]     key_chr;
    logic [PW-1:0]  pos_left;

    mte_ram #(
        .WIDTH (8),
        .DEPTH (NAME_CHARS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_nz    = vld_rd_reg && (ram_rdata != 8'd0);

    assign key_hit  = prev_vld_reg && (key_reg == prev_key_reg);
    assign tap_inc  = (tap_reg == TAP_LAST) ? 5'd0 : tap_reg + 5'd1;
    assign pos_adv  = (pos_reg < POS_MAX) ? pos_reg + POS_ONE : pos_reg;
    assign pos_key  = key_hit ? pos_reg : pos_adv;
    assign tap_key  = key_hit ? tap_inc : 5'd0;
    assign key_chr  = key_char(key_reg, tap_key, shift_reg);
    assign pos_left = (prev_vld_reg && pos_reg > POS_ONE) ? pos_reg - POS_ONE : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            prev_vld_reg <= 1'b0;
            prev_key_reg <= '0;
            tap_reg      <= '0;
            valid_reg    <= '0;
            vld_rd_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            prev_vld_reg <= prev_vld_next;
            prev_key_reg <= prev_key_next;
            tap_reg      <= tap_next;
            vld_rd_reg   <= valid_reg[rd_addr];
            if (ram_we) begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // captured transaction and pending result
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg  <= s_func;
            key_reg   <= s_key_digit;
            shift_reg <= s_shift_on;
            lidx_reg  <= s_load_index;
            lchr_reg  <= s_load_char;
        end
        res_rpt_reg  <= res_rpt_next;
        res_wr_reg   <= res_wr_next;
        res_widx_reg <= res_widx_next;
        res_wchr_reg <= res_wchr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_rpt_reg  <= res_rpt_reg;
            m_wr_reg   <= res_wr_reg;
            m_widx_reg <= res_widx_reg;
            m_wchr_reg <= res_wchr_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        prev_vld_next = prev_vld_reg;
        prev_key_next = prev_key_reg;
        tap_next      = tap_reg;
        res_rpt_next  = res_rpt_reg;
        res_wr_next   = res_wr_reg;
        res_widx_next = res_widx_reg;
        res_wchr_next = res_wchr_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        rd_addr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_wr_next   = 1'b0;
                res_widx_next = '0;
                res_wchr_next = '0;
                res_rpt_next  = 5'(pos_reg);
                state_next    = ST_DONE;
                case (func_reg)
                    FN_BEGIN: begin
                        prev_vld_next = 1'b0;
                        pos_next      = '0;
                        state_next    = ST_SCAN_RD;
                    end
                    FN_KEY: begin
                        if (key_reg <= KEY_MAX) begin
                            pos_next      = pos_key;
                            tap_next      = tap_key;
                            prev_vld_next = 1'b1;
                            prev_key_next = key_reg;
                            res_rpt_next  = 5'(pos_key) - 5'd1;
                            if (pos_key != '0) begin
                                ram_we        = 1'b1;
                                ram_waddr     = AW'(pos_key - POS_ONE);
                                ram_wdata     = {1'b0, key_chr};
                                res_wr_next   = 1'b1;
                                res_widx_next = 4'(pos_key - POS_ONE);
                                res_wchr_next = key_chr;
                            end
                        end
                    end
                    FN_COMMIT: begin
                        pos_next      = pos_adv;
                        prev_vld_next = 1'b0;
                        tap_next      = '0;
                        res_rpt_next  = 5'(pos_adv) - 5'd1;
                    end
                    FN_LEFT: begin
                        pos_next     = pos_left;
                        res_rpt_next = 5'(pos_left);
                        if (pos_left != '0) begin
                            pos_next      = pos_left - POS_ONE;
                            prev_vld_next = 1'b0;
                            tap_next      = '0;
                            res_rpt_next  = 5'(pos_left - POS_ONE);
                        end
                    end
                    FN_RIGHT: begin
                        if (pos_reg >= POS_MAX) begin
                            res_rpt_next = RPT_LAST;
                        end else if (pos_reg == '0) begin
                            // entry before the first counts as nonzero
                            if (prev_vld_reg) begin
                                prev_vld_next = 1'b0;
                            end else begin
                                rd_addr    = AW'(pos_reg);
                                state_next = ST_RGT_CHK1;
                            end
                        end else begin
                            rd_addr    = AW'(pos_reg - POS_ONE);
                            state_next = ST_RGT_CHK0;
                        end
                    end
                    FN_DELETE: begin
                        if (pos_reg != '0) begin
                            ram_we        = 1'b1;
                            ram_waddr     = AW'(pos_reg - POS_ONE);
                            ram_wdata     = 8'd0;
                            pos_next      = pos_reg - POS_ONE;
                            prev_vld_next = 1'b0;
                            tap_next      = '0;
                            res_rpt_next  = 5'(pos_reg - POS_ONE);
                        end
                    end
                    FN_LOAD: begin
                        if (int'(lidx_reg) < NAME_CHARS) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(lidx_reg);
                            ram_wdata = lchr_reg;
                        end
                    end
                    default: begin
                        res_rpt_next = 5'(pos_reg);
                    end
                endcase
            end

            ST_SCAN_RD: begin
                if (pos_reg < POS_MAX) begin
                    rd_addr    = AW'(pos_reg);
                    state_next = ST_SCAN_CHK;
                end else begin
                    res_rpt_next = 5'(pos_reg);
                    state_next   = ST_DONE;
                end
            end

            ST_SCAN_CHK: begin
                if (rd_nz) begin
                    pos_next = pos_reg + POS_ONE;
                    if (pos_reg + POS_ONE < POS_MAX) begin
                        rd_addr = AW'(pos_reg + POS_ONE);
                    end else begin
                        res_rpt_next = 5'(pos_reg + POS_ONE);
                        state_next   = ST_DONE;
                    end
                end else begin
                    res_rpt_next = 5'(pos_reg);
                    state_next   = ST_DONE;
                end
            end

            ST_RGT_CHK0: begin
                if (!rd_nz) begin
                    res_rpt_next = 5'(pos_reg) - 5'd1;
                    state_next   = ST_DONE;
                end else if (prev_vld_reg) begin
                    prev_vld_next = 1'b0;
                    state_next    = ST_DONE;
                end else begin
                    rd_addr    = AW'(pos_reg);
                    state_next = ST_RGT_CHK1;
                end
            end

            ST_RGT_CHK1: begin
                if (rd_nz) begin
                    pos_next      = pos_reg + POS_ONE;
                    prev_vld_next = 1'b0;
                    tap_next      = '0;
                    res_rpt_next  = 5'(pos_reg + POS_ONE);
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_report = m_rpt_reg;
    assign m_char_written  = m_wr_reg;
    assign m_written_index = m_widx_reg;
    assign m_written_char  = m_wchr_reg;

    // cursor never runs past the last entry
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("cursor position out of range");

    // tap count wraps before twenty
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_reg <= TAP_LAST)
        else $error("tap count out of range");

    // a remembered key is always a digit
    a_prev_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        prev_vld_reg |-> (prev_key_reg <= KEY_MAX))
        else $error("previous key not a digit");

    // the buffer is only written while a transaction is first executed
    a_write_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC))
        else $error("buffer write outside execute step");

    // a result is only presented after a transaction has finished
    a_result_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised without a finished transaction");

endmodule

`default_nettype wire

@@ rtl/core/mte_ram.sv @@
// ----------------------------------------------------------------------------
// mte_ram
// Generic single write port RAM with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ bench/multitap_text_entry_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multitap_text_entry_test
// Self-checking bench for the keypad multi-tap name editor. A queue of keypad
// events (directed edge cases, then random words, tap runs, edits, buffer
// fills and noise) is fed through the input channel with random gaps. Every
// accepted event is run through a local model of the editor, and each result
// transaction is compared field by field with the oldest outstanding
// prediction. The result side stalls at random and at intervals holds off for a long
// stretch.
// ----------------------------------------------------------------------------

module multitap_text_entry_test;
    import mte_pkg::*;

    localparam int         NAME_LEN   = 16;
    localparam logic [2:0] FN_UNUSED  = 3'd7;
    localparam int         CYCLE_CAP  = 400000;

    typedef struct {
        logic [2:0] func;
        logic [3:0] key;
        logic       shift;
        logic [3:0] lidx;
        logic [7:0] lchr;
        bit         drain;
    } keypad_event_t;

    typedef struct {
        logic [4:0] cursor;
        logic       wrote;
        logic [3:0] widx;
        logic [6:0] wchr;
    } entry_result_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic [2:0] s_func          = '0;
    logic [3:0] s_key_digit     = '0;
    logic       s_shift_on      = 1'b0;
    logic [3:0] s_load_index    = '0;
    logic [7:0] s_load_char     = '0;
    logic       m_ready         = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [4:0] m_cursor_report;
    logic       m_char_written;
    logic [3:0] m_written_index;
    logic [6:0] m_written_char;

    keypad_event_t pending_events[$];
    entry_result_t expected_reports[$];

    // editor model state
    logic [7:0] name_buf[NAME_LEN];
    int         cur_pos   = -1;
    int         last_key  = -1;
    int         taps      = 0;

    int sent_count    = 0;
    int checked_count = 0;
    int mismatches    = 0;
    int key_presses   = 0;
    int chars_written = 0;
    int tap_wraps     = 0;
    int full_scans    = 0;
    int cycle_count   = 0;
    int tx_wait       = 0;
    int rx_wait       = 0;
    int hold_left     = 0;
    int next_hold     = 150;
    int queued_count  = 0;
    bit drain_next    = 0;
    keypad_event_t held_event;
    logic rx_hold;

    multitap_text_entry #(
        .NAME_CHARS(NAME_LEN)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_key_digit     (s_key_digit),
        .s_shift_on      (s_shift_on),
        .s_load_index    (s_load_index),
        .s_load_char     (s_load_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_report (m_cursor_report),
        .m_char_written  (m_char_written),
        .m_written_index (m_written_index),
        .m_written_char  (m_written_char)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        foreach (name_buf[i]) name_buf[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [6:0] letter_for(int key, int tap, logic upper);
        string lst;
        byte   c;
        case (key)
            0: lst = " -&!0";
            1: lst = "/@.,1";
            2: lst = "ABC2";
            3: lst = "DEF3";
            4: lst = "GHI4";
            5: lst = "JKL5";
            6: lst = "MNO6";
            7: lst = "PQRS7";
            8: lst = "TUV8";
            default: lst = "WXYZ9";
        endcase
        c = lst[tap % lst.len()];
        if (!upper && c >= "A" && c <= "Z") begin
            c = c + 8'd32;
        end
        return c[6:0];
    endfunction

    function automatic logic [7:0] buf_at(int idx);
        if (idx < 0 || idx >= NAME_LEN) return 8'd0;
        return name_buf[idx];
    endfunction

    function automatic void step_cursor();
        if (cur_pos < NAME_LEN - 1) cur_pos++;
        last_key = -1;
        taps     = 0;
    endfunction

    // advance the editor model by one event and queue the result it gives
    function automatic void apply_event(keypad_event_t ev);
        entry_result_t r;
        int            rep;
        int            k;
        r   = '{default: '0};
        k   = int'(ev.key);
        rep = cur_pos + 1;
        case (ev.func)
            FN_BEGIN: begin
                last_key = -1;
                cur_pos  = -1;
                while (cur_pos + 1 < NAME_LEN && name_buf[cur_pos + 1] != 0) cur_pos++;
                if (cur_pos == NAME_LEN - 1) full_scans++;
                rep = cur_pos + 1;
            end
            FN_KEY: begin
                if (ev.key <= KEY_MAX) begin
                    key_presses++;
                    if (k == last_key) begin
                        if (taps == 19) tap_wraps++;
                        taps = (taps + 1) % 20;
                    end else begin
                        step_cursor();
                    end
                    if (cur_pos >= 0 && cur_pos < NAME_LEN) begin
                        r.wchr            = letter_for(k, taps, ev.shift);
                        name_buf[cur_pos] = {1'b0, r.wchr};
                        r.wrote           = 1'b1;
                        r.widx            = cur_pos[3:0];
                        chars_written++;
                    end
                    last_key = k;
                    rep      = cur_pos;
                end
            end
            FN_COMMIT: begin
                step_cursor();
                rep = cur_pos;
            end
            FN_LEFT: begin
                if (last_key != -1 && cur_pos > 0) cur_pos--;
                if (cur_pos > -1) begin
                    cur_pos--;
                    last_key = -1;
                    taps     = 0;
                end
                rep = cur_pos + 1;
            end
            FN_RIGHT: begin
                if (cur_pos < NAME_LEN - 1) begin
                    if (cur_pos < 0 || buf_at(cur_pos) != 0) begin
                        if (last_key != -1) begin
                            last_key = -1;
                        end else if (buf_at(cur_pos + 1) != 0) begin
                            step_cursor();
                        end
                        rep = cur_pos + 1;
                    end else begin
                        rep = cur_pos;
                    end
                end else begin
                    rep = NAME_LEN - 1;
                end
            end
            FN_DELETE: begin
                if (cur_pos > -1) begin
                    name_buf[cur_pos] = 8'd0;
                    cur_pos--;
                    last_key = -1;
                    taps     = 0;
                end
                rep = cur_pos + 1;
            end
            FN_LOAD: begin
                if (int'(ev.lidx) < NAME_LEN) name_buf[ev.lidx] = ev.lchr;
                rep = cur_pos + 1;
            end
            default: rep = cur_pos + 1;
        endcase
        r.cursor = rep[4:0];
        expected_reports.push_back(r);
    endfunction

    function automatic keypad_event_t rand_event();
        keypad_event_t ev;
        ev.func  = 3'($urandom_range(0, 7));
        ev.key   = 4'($urandom_range(0, 15));
        ev.shift = 1'($urandom_range(0, 1));
        ev.lidx  = 4'($urandom_range(0, 15));
        ev.lchr  = 8'($urandom_range(0, 255));
        ev.drain = 0;
        return ev;
    endfunction

    function automatic keypad_event_t ev_of(logic [2:0] f, logic [3:0] k, logic sh);
        keypad_event_t ev;
        ev       = rand_event();
        ev.func  = f;
        ev.key   = k;
        ev.shift = sh;
        return ev;
    endfunction

    function automatic keypad_event_t load_of(logic [3:0] idx, logic [7:0] chr);
        keypad_event_t ev;
        ev      = ev_of(FN_LOAD, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        ev.lidx = idx;
        ev.lchr = chr;
        return ev;
    endfunction

    function automatic void push_event(keypad_event_t ev);
        ev.drain   = drain_next;
        drain_next = 0;
        pending_events.push_back(ev);
        queued_count++;
    endfunction

    function automatic int draw_wait(bit brisk);
        return brisk ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic note_mismatch(string what, entry_result_t want, entry_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected cursor %0d wrote %0d index %0d char %h",
                     what, want.cursor, want.wrote, want.widx, want.wchr);
            $display("    got cursor %0d wrote %0d index %0d char %h",
                     got.cursor, got.wrote, got.widx, got.wchr);
        end
    endtask

    // stimulus
    initial begin : stimulus
        int kind, n, t, k, prev, next_drain;
        bit sh;

        // directed edge cases
        push_event(ev_of(FN_BEGIN, 0, 0));
        push_event(ev_of(FN_RIGHT, 0, 0));
        push_event(ev_of(FN_KEY, 2, 0));
        push_event(ev_of(FN_KEY, 2, 0));
        push_event(ev_of(FN_KEY, 2, 1));
        push_event(ev_of(FN_KEY, 2, 0));
        push_event(ev_of(FN_KEY, 7, 1));
        push_event(ev_of(FN_COMMIT, 0, 0));
        push_event(ev_of(FN_KEY, 0, 0));
        push_event(ev_of(FN_KEY, 1, 1));
        push_event(ev_of(FN_KEY, 9, 1));
        push_event(ev_of(FN_LEFT, 0, 0));
        push_event(ev_of(FN_RIGHT, 0, 0));
        push_event(ev_of(FN_DELETE, 0, 0));
        push_event(ev_of(FN_KEY, 15, 1));
        push_event(ev_of(FN_KEY, 10, 0));
        push_event(ev_of(FN_UNUSED, 3, 0));
        push_event(load_of(4'd15, 8'hff));
        push_event(load_of(4'd0, 8'h00));
        push_event(load_of(4'd0, 8'h41));
        push_event(ev_of(FN_BEGIN, 0, 0));
        push_event(ev_of(FN_RIGHT, 0, 0));
        push_event(ev_of(FN_DELETE, 0, 0));
        push_event(ev_of(FN_LEFT, 0, 0));

        next_drain = 170;
        while (queued_count < 1024) begin
            if (queued_count >= next_drain) begin
                drain_next = 1;
                next_drain += 170;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                // typed word
                n    = $urandom_range(1, 6);
                sh   = 1'($urandom_range(0, 1));
                prev = -1;
                for (int i = 0; i < n; i++) begin
                    k = $urandom_range(0, 9);
                    if (k == prev && $urandom_range(0, 3) != 0)
                        push_event(ev_of(FN_COMMIT, 0, 0));
                    t = $urandom_range(1, 5);
                    for (int j = 0; j < t; j++)
                        push_event(ev_of(FN_KEY, 4'(k),
                                         ($urandom_range(0, 7) == 0) ? !sh : sh));
                    prev = k;
                end
                if ($urandom_range(0, 1)) push_event(ev_of(FN_COMMIT, 0, 0));
            end else if (kind < 55) begin
                // cursor moves and erasures
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 2))
                        0: push_event(ev_of(FN_LEFT, 0, 0));
                        1: push_event(ev_of(FN_RIGHT, 0, 0));
                        default: push_event(ev_of(FN_DELETE, 0, 0));
                    endcase
                end
            end else if (kind < 62) begin
                // long tap run, up to and past the tap count wrap
                k = $urandom_range(0, 9);
                t = $urandom_range(18, 24);
                for (int j = 0; j < t; j++)
                    push_event(ev_of(FN_KEY, 4'(k), 1'($urandom_range(0, 1))));
            end else if (kind < 67) begin
                // fill the whole buffer, maybe with one terminator, then scan
                t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : -1;
                for (int i = 0; i < NAME_LEN; i++)
                    push_event(load_of(4'(i), (i == t) ? 8'd0 : 8'($urandom_range(1, 255))));
                push_event(ev_of(FN_BEGIN, 0, 0));
                push_event(ev_of(FN_RIGHT, 0, 0));
                push_event(ev_of(FN_KEY, 3, 1));
                push_event(ev_of(FN_KEY, 4, 0));
                push_event(ev_of(FN_COMMIT, 0, 0));
                push_event(ev_of(FN_RIGHT, 0, 0));
            end else if (kind < 72) begin
                push_event(ev_of(FN_BEGIN, 0, 0));
            end else if (kind < 80) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    push_event(load_of(4'($urandom_range(0, 15)),
                                       ($urandom_range(0, 3) == 0) ? 8'd0
                                                                   : 8'($urandom_range(0, 255))));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) push_event(rand_event());
            end
        end

        while (pending_events.size() != 0 || s_valid) @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("%0d events sent: %0d key presses, %0d characters written",
                 sent_count, key_presses, chars_written);
        $display("%0d tap count wraps, %0d scans of a full name, %0d results checked",
                 tap_wraps, full_scans, checked_count);
        if (mismatches == 0) begin
            $display("PASS multitap_text_entry");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL multitap_text_entry");
        end
        $finish;
    end

    // input side
    always @(posedge aclk) begin : tx_side
        keypad_event_t ev;
        bit            free;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= $urandom_range(0, 14);
        end else begin
            if (s_valid && s_ready) begin
                apply_event(held_event);
                sent_count <= sent_count + 1;
            end
            free = !s_valid || s_ready;
            if (free) begin
                if (tx_wait != 0) begin
                    tx_wait <= tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_events.size() != 0 &&
                             !(pending_events[0].drain && expected_reports.size() != 0)) begin
                    ev           = pending_events.pop_front();
                    held_event   = ev;
                    s_func       <= ev.func;
                    s_key_digit  <= ev.key;
                    s_shift_on   <= ev.shift;
                    s_load_index <= ev.lidx;
                    s_load_char  <= ev.lchr;
                    s_valid      <= 1'b1;
                    tx_wait      <= draw_wait(((sent_count / 80) % 4) == 3);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (sent_count >= next_hold) begin
            hold_left <= 300;
            next_hold <= next_hold + 400;
        end
    end
    assign rx_hold = (hold_left != 0);

    // result side
    always @(posedge aclk) begin : rx_side
        entry_result_t want;
        entry_result_t got;
        int            n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got.cursor = m_cursor_report;
                got.wrote  = m_char_written;
                got.widx   = m_written_index;
                got.wchr   = m_written_char;
                if (expected_reports.size() == 0) begin
                    note_mismatch("unexpected transaction", '{default: '0}, got);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.cursor !== want.cursor || got.wrote !== want.wrote ||
                        got.widx !== want.widx || got.wchr !== want.wchr)
                        note_mismatch("result mismatch", want, got);
                end
                checked_count <= checked_count + 1;
                n = draw_wait(((checked_count / 80) % 4) == 1);
                rx_wait <= n;
                m_ready <= (n == 0) && !rx_hold;
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= (rx_wait == 1) && !rx_hold;
            end else begin
                m_ready <= !rx_hold;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("timeout with %0d results outstanding", expected_reports.size());
            $display("FAIL multitap_text_entry");
            $finish;
        end
    end

endmodule
